// ===== design/satl_pkg.sv =====
// Shared constants, types and functions of the cache tag store.
`timescale 1ns / 1ps

package satl_pkg;

    // Cache geometry
    localparam int SET_COUNT  = 64;
    localparam int WAY_COUNT  = 4;
    localparam int LINE_BYTES = 32;

    // Significant address bits; higher bits read as zero
    localparam int ADDR_BITS = 32;

    // Fixed field widths
    localparam int ADDR_W    = 32;
    localparam int TAG_W     = 21;
    localparam int WAY_OUT_W = 2;
    localparam int LFSR_W    = 16;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;

    localparam logic [ADDR_W-1:0] ADDR_MASK =
        (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}}
                              : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

    typedef logic [LFSR_W-1:0] t_lfsr;

    // Access codes
    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANDOM_POLICY = CFG_IDX_W'(0),
        CFG_RANDOM_SEED   = CFG_IDX_W'(1)
    } t_cfg_reg;

    // Fibonacci step, taps x^16 + x^14 + x^13 + x^11 + 1, shifting right
    function automatic t_lfsr lfsr_step(input t_lfsr v);
        logic fb;
        fb = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {fb, v[LFSR_W-1:1]};
    endfunction

    // A zero seed would lock the LFSR; load it as one
    function automatic t_lfsr seed_load(input t_lfsr s);
        return (s == '0) ? t_lfsr'(1) : s;
    endfunction

endpackage

// ===== design/satl_if.sv =====
// Channel interfaces: access request, lookup response, configuration write.
`timescale 1ns / 1ps

interface satl_req_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [satl_pkg::ADDR_W-1:0]   address;

    modport source (output valid, output operation, output address, input ready);
    modport sink   (input valid, input operation, input address, output ready);
endinterface

interface satl_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            hit;
    logic [satl_pkg::WAY_OUT_W-1:0]  way;
    logic                            allocated;
    logic                            evicted;
    logic [satl_pkg::TAG_W-1:0]      evicted_tag;

    modport source (output valid, output hit, output way, output allocated,
                    output evicted, output evicted_tag, input ready);
    modport sink   (input valid, input hit, input way, input allocated,
                    input evicted, input evicted_tag, output ready);
endinterface

interface satl_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [satl_pkg::CFG_IDX_W-1:0]  index;
    logic [satl_pkg::CFG_DAT_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/satl_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps

module satl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read old data on a same-address write; hold when not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/set_assoc_cache_tag_lru.sv =====
// Set-associative cache tag store with per-way age counters and LRU/random victim choice.
// Timing: the accepting edge reads the set row into stage 1; stage 1 compares and updates,
//   and the result register loads when stage 1 fires, which a held result can delay.
// Throughput: one word per cycle; the set row is read and written back in one pass, a row
//   written at the same edge as the next read is forwarded, and a held result stalls input.
// Reset: synchronous, active low; all line valid bits clear at once, LRU mode, LFSR = 1.
`timescale 1ns / 1ps

module set_assoc_cache_tag_lru (
    input  logic       i_clk,
    input  logic       i_rst_n,
    satl_req_if.sink   i_req,
    satl_rsp_if.source o_rsp,
    satl_cfg_if.sink   i_cfg
);

    localparam int SET_COUNT  = satl_pkg::SET_COUNT;
    localparam int WAY_COUNT  = satl_pkg::WAY_COUNT;
    localparam int LINE_BYTES = satl_pkg::LINE_BYTES;
    localparam int OFF_BITS = $clog2(LINE_BYTES);
    localparam int SET_LOG  = $clog2(SET_COUNT);
    localparam int SET_W    = (SET_COUNT > 1) ? SET_LOG : 1;
    localparam int WAY_W    = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
    localparam int AGE_W    = WAY_W;
    localparam int TAG_W    = satl_pkg::TAG_W;
    localparam int ENT_W    = TAG_W + AGE_W;
    localparam int ROW_W    = WAY_COUNT * ENT_W;
    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WAY_COUNT - 1);

    // Stage 1 (row read) registers
    logic                  r_s1_valid;
    logic                  r_s1_write;
    logic [SET_W-1:0]      r_s1_set;
    logic [TAG_W-1:0]      r_s1_tag;
    logic                  r_s1_fwd;
    logic [ROW_W-1:0]      r_fwd_row;

    // Control state
    logic [WAY_COUNT-1:0]  r_valid [SET_COUNT];
    satl_pkg::t_lfsr       r_lfsr;
    logic                  r_policy;

    // Result register
    logic                                r_out_valid;
    logic                                r_out_hit;
    logic [satl_pkg::WAY_OUT_W-1:0]      r_out_way;
    logic                                r_out_alloc;
    logic                                r_out_evict;
    logic [TAG_W-1:0]                    r_out_evtag;

    logic                  in_fire;
    logic                  s1_fire;
    logic [31:0]           addr_m;
    logic [31:0]           line_addr;
    logic [SET_W-1:0]      in_set;
    logic [TAG_W-1:0]      in_tag;
    logic [ROW_W-1:0]      ram_rd_row;
    logic [ROW_W-1:0]      row;
    logic [ROW_W-1:0]      n_row;
    logic [TAG_W-1:0]      tags [WAY_COUNT];
    logic [AGE_W-1:0]      ages [WAY_COUNT];
    logic [WAY_COUNT-1:0]  set_valid;
    logic [WAY_COUNT-1:0]  hit_vec;
    logic                  hit;
    logic [WAY_W-1:0]      hit_way;
    logic                  any_invalid;
    logic [WAY_W-1:0]      inv_way;
    logic [WAY_W-1:0]      age_way;
    logic [AGE_W-1:0]      best_age;
    logic [WAY_W-1:0]      lfsr_way;
    logic [WAY_W-1:0]      victim;
    logic                  alloc;
    logic                  evict;
    logic                  touch;
    logic [WAY_W-1:0]      touch_way;
    logic [AGE_W-1:0]      mine;
    logic                  wr_en;
    logic [TAG_W-1:0]      ev_tag;

    // Handshakes
    assign s1_fire     = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || s1_fire;
    assign in_fire     = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    // Split the address into set and tag
    assign addr_m    = i_req.address & satl_pkg::ADDR_MASK;
    assign line_addr = addr_m >> OFF_BITS;
    assign in_set    = SET_W'(line_addr & 32'(SET_COUNT - 1));
    assign in_tag    = TAG_W'(addr_m >> (OFF_BITS + SET_LOG));

    // Tag and age rows, one row per set
    satl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SET_COUNT)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_set),
        .i_wr_data (n_row),
        .i_rd_en   (in_fire),
        .i_rd_addr (in_set),
        .o_rd_data (ram_rd_row)
    );

    // Take the forwarded row when it was written at the read edge
    assign row       = r_s1_fwd ? r_fwd_row : ram_rd_row;
    assign set_valid = r_valid[r_s1_set];

    always_comb begin
        for (int i = 0; i < WAY_COUNT; i++) begin
            tags[i] = row[i*ENT_W +: TAG_W];
            ages[i] = row[i*ENT_W + TAG_W +: AGE_W];
        end
    end

    // Compare all ways
    always_comb begin
        hit_way = '0;
        for (int i = WAY_COUNT - 1; i >= 0; i--) begin
            hit_vec[i] = set_valid[i] && (tags[i] == r_s1_tag);
            if (hit_vec[i]) begin
                hit_way = WAY_W'(i);
            end
        end
        hit = |hit_vec;
    end

    // Find the lowest invalid way
    always_comb begin
        inv_way = '0;
        for (int i = WAY_COUNT - 1; i >= 0; i--) begin
            if (!set_valid[i]) begin
                inv_way = WAY_W'(i);
            end
        end
        any_invalid = !(&set_valid);
    end

    // Find the oldest way, lowest index on a tie
    always_comb begin
        age_way  = '0;
        best_age = ages[0];
        for (int i = 1; i < WAY_COUNT; i++) begin
            if (ages[i] > best_age) begin
                age_way  = WAY_W'(i);
                best_age = ages[i];
            end
        end
    end

    assign lfsr_way = WAY_W'(r_lfsr & satl_pkg::t_lfsr'(WAY_COUNT - 1));

    // Pick the victim and classify the access
    always_comb begin
        if (any_invalid) begin
            victim = inv_way;
        end else if (r_policy) begin
            victim = lfsr_way;
        end else begin
            victim = age_way;
        end
        alloc     = !hit && (r_s1_write == satl_pkg::OP_WRITE);
        evict     = alloc && !any_invalid;
        touch     = hit || alloc;
        touch_way = hit ? hit_way : victim;
        mine      = hit ? ages[hit_way] : AGE_MAX;
        ev_tag    = evict ? tags[victim] : '0;
    end

    // Build the updated row: fill the victim, refresh ages in LRU mode
    always_comb begin
        for (int i = 0; i < WAY_COUNT; i++) begin
            logic          is_fill;
            logic [AGE_W-1:0] n_age;
            is_fill = alloc && (WAY_W'(i) == victim);
            if (r_policy) begin
                n_age = is_fill ? AGE_MAX : ages[i];
            end else if (WAY_W'(i) == touch_way) begin
                n_age = '0;
            end else if (set_valid[i] && (ages[i] < mine)) begin
                n_age = ages[i] + AGE_W'(1);
            end else begin
                n_age = ages[i];
            end
            n_row[i*ENT_W +: TAG_W]         = is_fill ? r_s1_tag : tags[i];
            n_row[i*ENT_W + TAG_W +: AGE_W] = n_age;
        end
    end

    assign wr_en = s1_fire && touch;

    // Advance stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_fwd   <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
                r_s1_fwd   <= wr_en && (r_s1_set == in_set);
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_write <= i_req.operation;
            r_s1_set   <= in_set;
            r_s1_tag   <= in_tag;
        end
        if (wr_en) begin
            r_fwd_row <= n_row;
        end
    end

    // Mark filled lines valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SET_COUNT; s++) begin
                r_valid[s] <= '0;
            end
        end else if (wr_en && alloc) begin
            r_valid[r_s1_set][victim] <= 1'b1;
        end
    end

    // Take configuration writes, advance the LFSR on a random eviction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= 1'b0;
            r_lfsr   <= satl_pkg::t_lfsr'(1);
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (satl_pkg::t_cfg_reg'(i_cfg.index))
                satl_pkg::CFG_RANDOM_POLICY: r_policy <= i_cfg.data[0];
                satl_pkg::CFG_RANDOM_SEED:
                    r_lfsr <= satl_pkg::seed_load(satl_pkg::t_lfsr'(i_cfg.data));
                default: ;
            endcase
        end else if (wr_en && evict && r_policy) begin
            r_lfsr <= satl_pkg::lfsr_step(r_lfsr);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_hit   <= hit;
            r_out_way   <= touch ? satl_pkg::WAY_OUT_W'(touch_way) : '0;
            r_out_alloc <= alloc;
            r_out_evict <= evict;
            r_out_evtag <= ev_tag;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.hit         = r_out_hit;
    assign o_rsp.way         = r_out_way;
    assign o_rsp.allocated   = r_out_alloc;
    assign o_rsp.evicted     = r_out_evict;
    assign o_rsp.evicted_tag = r_out_evtag;

    // Checks
    a_lfsr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lfsr != '0)
        else $error("replacement LFSR reached zero");

    a_fill_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && alloc) |=> r_valid[$past(r_s1_set)][$past(victim)])
        else $error("filled way not marked valid");

    a_evict_is_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.evicted) |-> (o_rsp.allocated && !o_rsp.hit))
        else $error("eviction reported without a fill");

    a_fwd_only_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !wr_en) |=> !r_s1_fwd)
        else $error("row forwarded without a write");

endmodule
